### rtl/core/mspid_pkg.sv
package mspid_pkg;

  // Field and register widths.
  localparam int PERIOD_W      = 16;
  localparam int NUM_W         = 17;
  localparam int GAIN_W        = 8;
  localparam int TARGET_W      = 8;
  localparam int ERR_W         = 18;
  localparam int CFG_IDX_W     = 3;
  localparam int CFG_DATA_W    = 17;

  // Structural constants.
  localparam int WINDOW_DEPTH  = 5;
  localparam int INTEGRAL_BITS = 24;

  localparam int IDX_W  = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;
  localparam int SUM_W  = PERIOD_W + $clog2(WINDOW_DEPTH);
  localparam int DVD_W  = NUM_W;
  localparam int DVS_W  = PERIOD_W;
  localparam int DCNT_W = $clog2(DVD_W + 1);

  // Window average by reciprocal multiplication: floor(sum / WINDOW_DEPTH) equals
  // (sum * AVG_RECIP) >> AVG_SHIFT for every sum the window can hold.
  localparam int AVG_SHIFT = SUM_W + $clog2(WINDOW_DEPTH);
  localparam int RECIP_W   = SUM_W + 1;
  localparam logic [RECIP_W-1:0] AVG_RECIP =
      RECIP_W'(((64'd1 << AVG_SHIFT) + 64'(WINDOW_DEPTH) - 64'd1) / 64'(WINDOW_DEPTH));

  // Integral accumulation width, one bit above the wider of the two addends.
  localparam int IS_W   = ((INTEGRAL_BITS > ERR_W) ? INTEGRAL_BITS : ERR_W) + 1;
  localparam logic signed [IS_W-1:0] INTEG_MAX =
      IS_W'((64'sd1 <<< (INTEGRAL_BITS - 1)) - 64'sd1);
  localparam logic signed [IS_W-1:0] INTEG_MIN =
      IS_W'(-(64'sd1 <<< (INTEGRAL_BITS - 1)));

  // Multiplier operand: must hold the integral, the error and the clamped derivative.
  localparam int OP_W   = (INTEGRAL_BITS > ERR_W + 1) ? INTEGRAL_BITS : ERR_W + 1;
  localparam int PROD_W = OP_W + GAIN_W + 1;
  localparam int ACC_W  = PROD_W + 2;

  localparam logic [PERIOD_W-1:0] WRAP_BASE = 16'hFF00;
  localparam logic [7:0]          PWM_MAX   = 8'd255;

  // Register reset values.
  localparam logic [NUM_W-1:0]  RST_NUMERATOR = 17'd125000;
  localparam logic [GAIN_W-1:0] RST_KP        = 8'd77;
  localparam logic [GAIN_W-1:0] RST_KI        = 8'd26;
  localparam logic [GAIN_W-1:0] RST_KD        = 8'd13;
  localparam logic [7:0]        RST_FLOOR     = 8'd20;
  localparam logic [7:0]        RST_OPEN      = 8'd15;
  localparam logic [7:0]        RST_STOP      = 8'd10;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_RPM_NUMERATOR = 3'd0,
    CFG_GAIN_P        = 3'd1,
    CFG_GAIN_I        = 3'd2,
    CFG_GAIN_D        = 3'd3,
    CFG_AVG_FLOOR     = 3'd4,
    CFG_OPEN_LOOP     = 3'd5,
    CFG_STOP          = 3'd6
  } cfg_reg_e;

  typedef enum logic {
    OP_CAPTURE = 1'b0,
    OP_CONTROL = 1'b1
  } op_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SUM,
    ST_AVG,
    ST_DIV_RPM,
    ST_FLOOR,
    ST_DIV_SINGLE,
    ST_PID,
    ST_MAC,
    ST_FINISH
  } state_e;

  typedef struct packed {
    logic             start;
    logic [DVD_W-1:0] dividend;
    logic [DVS_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [DVD_W-1:0] quotient;
  } div_rsp_t;

endpackage

### rtl/core/mspid_div.sv
// Restoring divider, one quotient bit per cycle. A zero divisor is handled by the caller.
module mspid_div
  import mspid_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  div_req_t req_i,
  output div_rsp_t rsp_o
);

  logic              busy_q;
  logic              done_q;
  logic [DCNT_W-1:0] cnt_q;
  logic [DVD_W-1:0]  quo_q;
  logic [DVS_W-1:0]  rem_q;
  logic [DVS_W-1:0]  dvs_q;

  logic [DVS_W:0]    shifted;
  logic [DVS_W+1:0]  diff;
  logic              fits;

  assign shifted = {rem_q, quo_q[DVD_W-1]};
  assign diff    = {1'b0, shifted} - {2'b00, dvs_q};
  assign fits    = ~diff[DVS_W+1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start && !busy_q) begin
        busy_q <= 1'b1;
        cnt_q  <= DCNT_W'(DVD_W);
      end else if (busy_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == DCNT_W'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start && !busy_q) begin
      quo_q <= req_i.dividend;
      rem_q <= '0;
      dvs_q <= req_i.divisor;
    end else if (busy_q) begin
      rem_q <= fits ? diff[DVS_W-1:0] : shifted[DVS_W-1:0];
      quo_q <= {quo_q[DVD_W-2:0], fits};
    end
  end

  assign rsp_o.done     = done_q;
  assign rsp_o.quotient = quo_q;

endmodule

### rtl/core/motor_speed_pid_from_capture.sv
// Motor speed PID controller fed by edge capture. A request with operation 0 is a
// capture edge: it updates the stored period, gives no result and leaves the block
// idle, so the next request can be taken on the following cycle. A request with
// operation 1 is a control step that gives exactly one result; it divides the single
// period too when the averaged speed is at or below the floor, and it is shorter
// when a divisor is zero. The speed divisions use the serial restoring divider, which
// yields one quotient bit per cycle and is shared by both of them; the window sum adds
// the window entries one after another, the window average is a reciprocal
// multiplication, and the three PID products go through one shared multiplier in
// turn.
// A control step also waits in its finish state while an earlier result is
// still stalled at the output. in_stall_o is high for the whole control step. A
// finished result sits in an output register, so the block takes new requests while
// a result is still waiting to be taken. Configuration registers are written through
// cfg_we_i, cfg_index_i and cfg_data_i and must only change while the block is idle.
module motor_speed_pid_from_capture
  import mspid_pkg::*;
(
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    in_valid_i,
  output logic                    in_stall_o,
  input  logic                    operation_i,
  input  logic [PERIOD_W-1:0]     capture_time_i,
  input  logic [TARGET_W-1:0]     target_speed_i,
  input  logic                    cfg_we_i,
  input  logic [CFG_IDX_W-1:0]    cfg_index_i,
  input  logic [CFG_DATA_W-1:0]   cfg_data_i,
  output logic                    out_valid_o,
  input  logic                    out_stall_i,
  output logic [7:0]              pwm_compare_o,
  output logic [NUM_W-1:0]        measured_rpm_o,
  output logic signed [ERR_W-1:0] speed_error_o
);

  // Configuration registers.
  logic [NUM_W-1:0]  num_q;
  logic [GAIN_W-1:0] kp_q, ki_q, kd_q;
  logic [7:0]        floor_q, open_q, stop_q;

  // Controller state kept across requests.
  logic [PERIOD_W-1:0]            last_capture_q;
  logic [PERIOD_W-1:0]            latest_q;
  logic [PERIOD_W-1:0]            window_q [WINDOW_DEPTH];
  logic signed [INTEGRAL_BITS-1:0] integ_q;
  logic signed [ERR_W-1:0]        prev_err_q;
  logic [TARGET_W-1:0]            prev_target_q;

  // Sequencer.
  state_e           state_q, state_d;
  logic             launch_q;
  logic [IDX_W-1:0] idx_q;
  logic [1:0]       mac_k_q;
  logic             out_valid_q;

  // Per-request working registers.
  logic [TARGET_W-1:0]     target_q;
  logic [SUM_W-1:0]        sum_q;
  logic [PERIOD_W-1:0]     avg_q;
  logic [NUM_W-1:0]        rpm_q;
  logic signed [ERR_W-1:0] err_q;
  logic [ERR_W-1:0]        deriv_q;
  logic signed [PROD_W-1:0] prod_q;
  logic signed [ACC_W-1:0] acc_q;

  logic [7:0]              pwm_q;
  logic [NUM_W-1:0]        rpm_out_q;
  logic signed [ERR_W-1:0] err_out_q;

  div_req_t div_req;
  div_rsp_t div_rsp;

  logic in_acc, ctrl_acc, cap_acc, out_load, div_zero;

  assign in_acc   = in_valid_i && !in_stall_o;
  assign ctrl_acc = in_acc && (operation_i == OP_CONTROL);
  assign cap_acc  = in_acc && (operation_i == OP_CAPTURE);
  assign out_load = (state_q == ST_FINISH) && (!out_valid_q || !out_stall_i);
  assign div_zero = (div_req.divisor == '0);

  mspid_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  // Period since the previous edge. When the new stamp is not larger, the timer is
  // taken to have wrapped at 0xFF00, and the difference is kept modulo 2^16.
  logic [PERIOD_W-1:0] period_new;
  always_comb begin
    if (capture_time_i > last_capture_q) begin
      period_new = capture_time_i - last_capture_q;
    end else begin
      period_new = WRAP_BASE + capture_time_i - last_capture_q;
    end
  end

  // Window average: the sum times the rounded-up reciprocal of the depth. The
  // quotient sits in the bits from AVG_SHIFT up and always fits a period.
  logic [SUM_W+RECIP_W-1:0] avg_prod;
  assign avg_prod = sum_q * AVG_RECIP;

  // Error, saturating integral and clamped derivative for the PID step.
  logic signed [ERR_W-1:0]         err_now;
  logic signed [IS_W-1:0]          integ_sum;
  logic signed [INTEGRAL_BITS-1:0] integ_sat;
  logic signed [ERR_W:0]           deriv_full;
  logic [ERR_W-1:0]                deriv_now;

  always_comb begin
    err_now   = $signed({{(ERR_W-TARGET_W){1'b0}}, target_q}) - $signed({1'b0, rpm_q});
    integ_sum = IS_W'(integ_q) + IS_W'(err_now);
    if (integ_sum > INTEG_MAX) begin
      integ_sat = INTEGRAL_BITS'(INTEG_MAX);
    end else if (integ_sum < INTEG_MIN) begin
      integ_sat = INTEGRAL_BITS'(INTEG_MIN);
    end else begin
      integ_sat = INTEGRAL_BITS'(integ_sum);
    end
    deriv_full = $signed({err_now[ERR_W-1], err_now})
               - $signed({prev_err_q[ERR_W-1], prev_err_q});
    deriv_now  = deriv_full[ERR_W] ? '0 : deriv_full[ERR_W-1:0];
  end

  // Shared multiplier: one gain times one PID term per cycle.
  logic signed [GAIN_W:0]   mul_a;
  logic signed [OP_W-1:0]   mul_b;
  logic signed [PROD_W-1:0] product;

  always_comb begin
    case (mac_k_q)
      2'd0: begin
        mul_a = $signed({1'b0, kp_q});
        mul_b = OP_W'(err_q);
      end
      2'd1: begin
        mul_a = $signed({1'b0, ki_q});
        mul_b = OP_W'(integ_q);
      end
      2'd2: begin
        mul_a = $signed({1'b0, kd_q});
        mul_b = $signed(OP_W'(deriv_q));
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign product = mul_a * mul_b;

  // Drive from the accumulated sum. A negative sum truncates toward zero and then
  // clamps to zero, so only the sign and the bits above the Q8 point matter.
  logic [7:0]              drive_pid, drive;
  logic [NUM_W-1:0]        rpm_final;
  logic signed [ERR_W-1:0] err_final;

  always_comb begin
    if (acc_q[ACC_W-1]) begin
      drive_pid = '0;
    end else if (|acc_q[ACC_W-2:16]) begin
      drive_pid = PWM_MAX;
    end else begin
      drive_pid = acc_q[15:8];
    end
    if (target_q <= stop_q) begin
      drive     = '0;
      rpm_final = '0;
    end else if (target_q <= open_q) begin
      drive     = target_q;
      rpm_final = NUM_W'(target_q);
    end else begin
      drive     = drive_pid;
      rpm_final = rpm_q;
    end
    err_final = $signed({{(ERR_W-TARGET_W){1'b0}}, target_q}) - $signed({1'b0, rpm_final});
  end

  // Sequencer next state and divider requests.
  always_comb begin
    state_d          = state_q;
    div_req.start    = 1'b0;
    div_req.dividend = DVD_W'(num_q);
    div_req.divisor  = latest_q;
    unique case (state_q)
      ST_IDLE: begin
        if (ctrl_acc) begin
          state_d = ST_SUM;
        end
      end
      ST_SUM: begin
        if (idx_q == IDX_W'(WINDOW_DEPTH - 1)) begin
          state_d = ST_AVG;
        end
      end
      ST_AVG: begin
        state_d = ST_DIV_RPM;
      end
      ST_DIV_RPM: begin
        div_req.divisor = avg_q;
        div_req.start   = !launch_q && !div_zero;
        if (div_zero || div_rsp.done) begin
          state_d = ST_FLOOR;
        end
      end
      ST_FLOOR: begin
        if (rpm_q <= NUM_W'(floor_q)) begin
          state_d = ST_DIV_SINGLE;
        end else begin
          state_d = ST_PID;
        end
      end
      ST_DIV_SINGLE: begin
        div_req.start = !launch_q && !div_zero;
        if (div_zero || div_rsp.done) begin
          state_d = ST_PID;
        end
      end
      ST_PID: begin
        state_d = ST_MAC;
      end
      ST_MAC: begin
        if (mac_k_q == 2'd3) begin
          state_d = ST_FINISH;
        end
      end
      ST_FINISH: begin
        if (out_load) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Control and persistent state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      num_q          <= RST_NUMERATOR;
      kp_q           <= RST_KP;
      ki_q           <= RST_KI;
      kd_q           <= RST_KD;
      floor_q        <= RST_FLOOR;
      open_q         <= RST_OPEN;
      stop_q         <= RST_STOP;
      launch_q       <= 1'b0;
      idx_q          <= '0;
      mac_k_q        <= '0;
      out_valid_q    <= 1'b0;
      last_capture_q <= '0;
      latest_q       <= '0;
      window_q       <= '{default: '0};
      integ_q        <= '0;
      prev_err_q     <= '0;
      prev_target_q  <= '0;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_index_i)
          CFG_RPM_NUMERATOR: num_q   <= cfg_data_i;
          CFG_GAIN_P:        kp_q    <= cfg_data_i[GAIN_W-1:0];
          CFG_GAIN_I:        ki_q    <= cfg_data_i[GAIN_W-1:0];
          CFG_GAIN_D:        kd_q    <= cfg_data_i[GAIN_W-1:0];
          CFG_AVG_FLOOR:     floor_q <= cfg_data_i[7:0];
          CFG_OPEN_LOOP:     open_q  <= cfg_data_i[7:0];
          CFG_STOP:          stop_q  <= cfg_data_i[7:0];
          default: ;
        endcase
      end

      if (div_rsp.done) begin
        launch_q <= 1'b0;
      end else if (div_req.start) begin
        launch_q <= 1'b1;
      end

      if (state_q == ST_IDLE) begin
        idx_q <= '0;
      end else if (state_q == ST_SUM) begin
        idx_q <= idx_q + 1'b1;
      end

      if (state_q == ST_PID) begin
        mac_k_q <= '0;
      end else if (state_q == ST_MAC) begin
        mac_k_q <= mac_k_q + 1'b1;
      end

      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end

      if (cap_acc) begin
        latest_q       <= period_new;
        last_capture_q <= capture_time_i;
      end

      // A control step drops the oldest period and appends the latest one. A new
      // target restarts the integral.
      if (ctrl_acc) begin
        for (int k = 0; k < WINDOW_DEPTH - 1; k++) begin
          window_q[k] <= window_q[k+1];
        end
        window_q[WINDOW_DEPTH-1] <= latest_q;
        if (target_speed_i != prev_target_q) begin
          integ_q <= '0;
        end
        prev_target_q <= target_speed_i;
      end

      if (state_q == ST_PID) begin
        integ_q    <= integ_sat;
        prev_err_q <= err_now;
      end
    end
  end

  // Working registers of the current control step.
  always_ff @(posedge clk_i) begin
    if (ctrl_acc) begin
      target_q <= target_speed_i;
      sum_q    <= '0;
    end
    if (state_q == ST_SUM) begin
      sum_q <= sum_q + SUM_W'(window_q[idx_q]);
    end
    if (state_q == ST_AVG) begin
      avg_q <= avg_prod[AVG_SHIFT +: PERIOD_W];
    end
    if ((state_q == ST_DIV_RPM) || (state_q == ST_DIV_SINGLE)) begin
      if (div_zero) begin
        rpm_q <= num_q;
      end else if (div_rsp.done) begin
        rpm_q <= div_rsp.quotient[NUM_W-1:0];
      end
    end
    if (state_q == ST_PID) begin
      err_q   <= err_now;
      deriv_q <= deriv_now;
      acc_q   <= '0;
    end
    if (state_q == ST_MAC) begin
      if (mac_k_q != 2'd3) begin
        prod_q <= product;
      end
      if (mac_k_q != 2'd0) begin
        acc_q <= acc_q + ACC_W'(prod_q);
      end
    end
    if (out_load) begin
      pwm_q     <= PWM_MAX - drive;
      rpm_out_q <= rpm_final;
      err_out_q <= err_final;
    end
  end

  assign in_stall_o     = (state_q != ST_IDLE);
  assign out_valid_o    = out_valid_q;
  assign pwm_compare_o  = pwm_q;
  assign measured_rpm_o = rpm_out_q;
  assign speed_error_o  = err_out_q;

endmodule

### rtl/core/mspid_chk.sv
// Port-level checks for the speed controller.
module mspid_chk (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               in_valid_i,
  input logic               in_stall_o,
  input logic               operation_i,
  input logic [15:0]        capture_time_i,
  input logic [7:0]         target_speed_i,
  input logic               cfg_we_i,
  input logic [2:0]         cfg_index_i,
  input logic [16:0]        cfg_data_i,
  input logic               out_valid_o,
  input logic               out_stall_i,
  input logic [7:0]         pwm_compare_o,
  input logic [16:0]        measured_rpm_o,
  input logic signed [17:0] speed_error_o
);

  logic [18:0] target_sum;
  assign target_sum = {2'b00, measured_rpm_o} + {speed_error_o[17], speed_error_o};

  // A control request keeps the block busy on the next cycle.
  a_ctrl_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
      (in_valid_i && !in_stall_o && operation_i) |=> in_stall_o)
    else $error("control request did not start a busy period");

  // A capture request leaves the block free on the next cycle.
  a_cap_quick: assert property (@(posedge clk_i) disable iff (!rst_ni)
      (in_valid_i && !in_stall_o && !operation_i) |=> !in_stall_o)
    else $error("capture request held the block busy");

  // Speed plus error always gives back an 8-bit target.
  a_err_consistent: assert property (@(posedge clk_i) disable iff (!rst_ni)
      out_valid_o |-> (target_sum[18:8] == 11'd0))
    else $error("speed error does not match the reported speed");

  // A new result only appears at the end of a busy period.
  a_result_from_work: assert property (@(posedge clk_i) disable iff (!rst_ni)
      $rose(out_valid_o) |-> $past(in_stall_o))
    else $error("result appeared without a control step");

  // A stalled result holds.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
      (out_valid_o && out_stall_i) |=> (out_valid_o && $stable(pwm_compare_o)
        && $stable(measured_rpm_o) && $stable(speed_error_o)))
    else $error("stalled result changed");

endmodule

bind motor_speed_pid_from_capture mspid_chk u_mspid_chk (.*);
